// ===== hdl/cmag_pkg.sv =====
// shared widths, types and register codes for the complex magnitude block
`default_nettype none

package cmag_pkg;

   // width of each part of the complex word on the ports
   localparam int FIELD_WIDTH = 25;
   // number of input bits that are significant
   localparam int INPUT_WIDTH = 25;
   // operand width actually used
   localparam int OP_WIDTH = (INPUT_WIDTH < FIELD_WIDTH) ? INPUT_WIDTH : FIELD_WIDTH;

   // sum of squares, one root bit per cell
   localparam int SQ_WIDTH     = 2 * OP_WIDTH;
   localparam int CELL_COUNT   = OP_WIDTH;
   localparam int ROOT_WIDTH   = OP_WIDTH;
   localparam int REM_WIDTH    = ROOT_WIDTH + 2;
   localparam int APPROX_WIDTH = OP_WIDTH + 1;

   // shifts of the minimum in the approximate form
   localparam int MIN_SHIFT_A = 2;
   localparam int MIN_SHIFT_B = 3;

   // pipeline depth: front stages, root cells, output register
   localparam int FRONT_STAGES = 3;
   localparam int LATENCY      = FRONT_STAGES + CELL_COUNT + 1;

   // register port
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 32;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_APPROX_MODE = 2'd0
   } csr_addr_type;

   // word handed from cell to cell
   typedef struct packed {
      logic                    valid;
      logic                    mode;
      logic [SQ_WIDTH-1:0]     radicand;
      logic [REM_WIDTH-1:0]    rem;
      logic [ROOT_WIDTH-1:0]   root;
      logic [APPROX_WIDTH-1:0] approx;
   } cell_word_type;

endpackage

`default_nettype wire

// ===== hdl/cmag_front.sv =====
// front stages: absolute values, squares, sum and approximate magnitude
`default_nettype none

module cmag_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               accept,
   input  wire logic                               mode,
   input  wire logic [cmag_pkg::FIELD_WIDTH-1:0]   real_part,
   input  wire logic [cmag_pkg::FIELD_WIDTH-1:0]   imag_part,
   output cmag_pkg::cell_word_type                 word_out
);

   logic [cmag_pkg::OP_WIDTH-1:0]     re_raw;
   logic [cmag_pkg::OP_WIDTH-1:0]     im_raw;
   logic [cmag_pkg::OP_WIDTH-1:0]     re_abs_in;
   logic [cmag_pkg::OP_WIDTH-1:0]     im_abs_in;

   logic                              s1_valid_ff;
   logic                              s1_mode_ff;
   logic [cmag_pkg::OP_WIDTH-1:0]     re_abs_ff;
   logic [cmag_pkg::OP_WIDTH-1:0]     im_abs_ff;

   logic                              s2_valid_ff;
   logic                              s2_mode_ff;
   logic [cmag_pkg::SQ_WIDTH-1:0]     sq_re_ff;
   logic [cmag_pkg::SQ_WIDTH-1:0]     sq_im_ff;
   logic [cmag_pkg::OP_WIDTH-1:0]     hi_ff;
   logic [cmag_pkg::OP_WIDTH-1:0]     lo_ff;
   logic [cmag_pkg::SQ_WIDTH-1:0]     sq_re_in;
   logic [cmag_pkg::SQ_WIDTH-1:0]     sq_im_in;
   logic [cmag_pkg::OP_WIDTH-1:0]     hi_in;
   logic [cmag_pkg::OP_WIDTH-1:0]     lo_in;

   logic                              s3_valid_ff;
   logic                              s3_mode_ff;
   logic [cmag_pkg::SQ_WIDTH-1:0]     sum_ff;
   logic [cmag_pkg::APPROX_WIDTH-1:0] approx_ff;
   logic [cmag_pkg::SQ_WIDTH-1:0]     sum_in;
   logic [cmag_pkg::APPROX_WIDTH-1:0] approx_in;

   // keep the low bits and take the magnitude; the most negative value stays exact
   assign re_raw    = real_part[cmag_pkg::OP_WIDTH-1:0];
   assign im_raw    = imag_part[cmag_pkg::OP_WIDTH-1:0];
   assign re_abs_in = re_raw[cmag_pkg::OP_WIDTH-1]
                    ? (~re_raw + cmag_pkg::OP_WIDTH'(1)) : re_raw;
   assign im_abs_in = im_raw[cmag_pkg::OP_WIDTH-1]
                    ? (~im_raw + cmag_pkg::OP_WIDTH'(1)) : im_raw;

   // stage one: absolute values
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_mode_ff <= mode;
      re_abs_ff  <= re_abs_in;
      im_abs_ff  <= im_abs_in;
   end

   // squares and ordering of the two magnitudes
   assign sq_re_in = cmag_pkg::SQ_WIDTH'(re_abs_ff) * cmag_pkg::SQ_WIDTH'(re_abs_ff);
   assign sq_im_in = cmag_pkg::SQ_WIDTH'(im_abs_ff) * cmag_pkg::SQ_WIDTH'(im_abs_ff);
   assign hi_in    = (re_abs_ff > im_abs_ff) ? re_abs_ff : im_abs_ff;
   assign lo_in    = (re_abs_ff > im_abs_ff) ? im_abs_ff : re_abs_ff;

   // stage two: squares
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_mode_ff <= s1_mode_ff;
      sq_re_ff   <= sq_re_in;
      sq_im_ff   <= sq_im_in;
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
   end

   // sum of squares and max plus three eighths of min
   assign sum_in    = sq_re_ff + sq_im_ff;
   assign approx_in = cmag_pkg::APPROX_WIDTH'(hi_ff)
                    + cmag_pkg::APPROX_WIDTH'(lo_ff >> cmag_pkg::MIN_SHIFT_A)
                    + cmag_pkg::APPROX_WIDTH'(lo_ff >> cmag_pkg::MIN_SHIFT_B);

   // stage three: radicand ready for the root cells
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_mode_ff <= s2_mode_ff;
      sum_ff     <= sum_in;
      approx_ff  <= approx_in;
   end

   // word into the first cell, root and remainder start at zero
   always_comb begin
      word_out          = '0;
      word_out.valid    = s3_valid_ff;
      word_out.mode     = s3_mode_ff;
      word_out.radicand = sum_ff;
      word_out.approx   = approx_ff;
   end

endmodule

`default_nettype wire

// ===== hdl/cmag_cell.sv =====
// one root cell: settles one bit of the integer square root
`default_nettype none

module cmag_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cmag_pkg::cell_word_type word_in,
   output cmag_pkg::cell_word_type      word_out
);

   logic [cmag_pkg::REM_WIDTH-1:0]    rem_shift;
   logic [cmag_pkg::REM_WIDTH-1:0]    trial;
   logic                              take;

   logic                              valid_ff;
   logic                              mode_ff;
   logic [cmag_pkg::SQ_WIDTH-1:0]     radicand_ff;
   logic [cmag_pkg::REM_WIDTH-1:0]    rem_ff;
   logic [cmag_pkg::ROOT_WIDTH-1:0]   root_ff;
   logic [cmag_pkg::APPROX_WIDTH-1:0] approx_ff;

   logic [cmag_pkg::SQ_WIDTH-1:0]     radicand_in;
   logic [cmag_pkg::REM_WIDTH-1:0]    rem_in;
   logic [cmag_pkg::ROOT_WIDTH-1:0]   root_in;

   // bring down the next two radicand bits and try root*4+1
   assign rem_shift = {word_in.rem[cmag_pkg::REM_WIDTH-3:0],
                       word_in.radicand[cmag_pkg::SQ_WIDTH-1 -: 2]};
   assign trial     = {word_in.root, 2'b01};
   assign take      = (rem_shift >= trial);

   assign rem_in      = take ? (rem_shift - trial) : rem_shift;
   assign root_in     = {word_in.root[cmag_pkg::ROOT_WIDTH-2:0], take};
   assign radicand_in = {word_in.radicand[cmag_pkg::SQ_WIDTH-3:0], 2'b00};

   // cell register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= word_in.valid;
      end
      mode_ff     <= word_in.mode;
      radicand_ff <= radicand_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      approx_ff   <= word_in.approx;
   end

   // hand on to the next cell
   always_comb begin
      word_out.valid    = valid_ff;
      word_out.mode     = mode_ff;
      word_out.radicand = radicand_ff;
      word_out.rem      = rem_ff;
      word_out.root     = root_ff;
      word_out.approx   = approx_ff;
   end

endmodule

`default_nettype wire

// ===== hdl/complex_magnitude_top.sv =====
// top level of the complex magnitude block: register port, front stages, root cell chain
//
// Usage
//  - input channel: drive req_real_part and req_imag_part with start high; a word is
//    taken at each clock edge where start is high and busy is low. busy stays low, so a
//    new word can be given on every cycle.
//  - result channel: rsp_valid rises with rsp_magnitude after the word has passed
//    through 3 front stages, 25 root cells and 1 output register, in that order.
//    Throughput is one word per cycle; results stay in order.
//  - the result cannot be held off: the receiver must take it in the cycle it is shown.
//  - approx_mode at byte address 0 (bit 0): 0 gives floor(sqrt(re^2 + im^2)) from a
//    chain of cells that each settle one root bit, 1 gives max + min/4 + min/8.
//    The mode is sampled with each word; write it only while no word is in flight.
//  - reset (synchronous) empties the pipeline and sets approx_mode to 0; nothing else
//    is stored, so no clearing pass is needed.
`default_nettype none

module complex_magnitude_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input channel
   input  wire logic                                 start,
   output wire logic                                 busy,
   input  wire logic [cmag_pkg::FIELD_WIDTH-1:0]     req_real_part,
   input  wire logic [cmag_pkg::FIELD_WIDTH-1:0]     req_imag_part,
   // result channel
   output wire logic                                 rsp_valid,
   output wire logic [cmag_pkg::FIELD_WIDTH-1:0]     rsp_magnitude,
   // register port
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [cmag_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  wire logic [cmag_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output wire logic [cmag_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output wire logic                                 pready
);

   logic                                accept;
   logic                                csr_write;
   logic                                approx_mode_ff;
   logic                                approx_mode_in;
   cmag_pkg::cell_word_type             chain [0:cmag_pkg::CELL_COUNT];

   logic                                rsp_valid_ff;
   logic [cmag_pkg::FIELD_WIDTH-1:0]    rsp_magnitude_ff;
   logic [cmag_pkg::FIELD_WIDTH-1:0]    rsp_magnitude_in;

   // handshake: the pipeline takes a word every cycle
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // register port, always ready
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready
                    & (paddr == cmag_pkg::CSR_APPROX_MODE);
   assign approx_mode_in = csr_write ? pwdata[0] : approx_mode_ff;
   assign prdata = (paddr == cmag_pkg::CSR_APPROX_MODE)
                 ? {{(cmag_pkg::CSR_DATA_WIDTH-1){1'b0}}, approx_mode_ff}
                 : '0;

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         approx_mode_ff <= 1'b0;
      end else begin
         approx_mode_ff <= approx_mode_in;
      end
   end

   // front stages
   cmag_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .mode      (approx_mode_ff),
      .real_part (req_real_part),
      .imag_part (req_imag_part),
      .word_out  (chain[0])
   );

   // chain of root cells
   for (genvar i = 0; i < cmag_pkg::CELL_COUNT; i++) begin : g_cell
      cmag_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .word_in  (chain[i]),
         .word_out (chain[i+1])
      );
   end

   // pick the form selected for this word
   assign rsp_magnitude_in = chain[cmag_pkg::CELL_COUNT].mode
      ? cmag_pkg::FIELD_WIDTH'(chain[cmag_pkg::CELL_COUNT].approx)
      : cmag_pkg::FIELD_WIDTH'(chain[cmag_pkg::CELL_COUNT].root);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= chain[cmag_pkg::CELL_COUNT].valid;
      end
      rsp_magnitude_ff <= rsp_magnitude_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = rsp_magnitude_ff;

   // every result matches one word taken a fixed latency earlier
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(accept && !reset, cmag_pkg::LATENCY))
      else $error("result strobe out of step with accepted words");

   // a write to the mode register takes effect on the next cycle
   a_mode_write : assert property (@(posedge clock) disable iff (reset)
      csr_write |=> (approx_mode_ff == $past(pwdata[0])))
      else $error("mode register did not take the written value");

   // the root cells never leave a remainder above twice the root
   a_root_rem : assert property (@(posedge clock) disable iff (reset)
      chain[cmag_pkg::CELL_COUNT].valid |->
         ({1'b0, chain[cmag_pkg::CELL_COUNT].rem} <=
          {chain[cmag_pkg::CELL_COUNT].root, 1'b0}))
      else $error("square root remainder out of range");

endmodule

`default_nettype wire
